[rtl/core/olfid_pkg.sv]
`timescale 1ns / 1ps

package olfid_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STATUS_INSERTED  = 3'd0,
		STATUS_FULL      = 3'd1,
		STATUS_REMOVED   = 3'd2,
		STATUS_NOT_FOUND = 3'd3,
		STATUS_ENTRY     = 3'd4,
		STATUS_EMPTY     = 3'd5,
		STATUS_CLEARED   = 3'd6
	} status_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [VALUE_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  item_value;
		logic [COUNT_W-1:0]         entry_count;
		logic                       last;
	} out_item_t;

	// operation that every cell carries out
	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH       = 3'd1,
		CELL_COMPARE    = 3'd2,
		CELL_PULL_MATCH = 3'd3,
		CELL_PULL       = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [VALUE_W-1:0]  key;
	} cell_ctl_t;

endpackage

[rtl/core/olfid_stream_if.sv]
`timescale 1ns / 1ps

interface olfid_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/olfid_cell.sv]
`timescale 1ns / 1ps

module olfid_cell (
	input  logic                                   clk,
	input  olfid_pkg::cell_ctl_t                   ctl,
	input  logic signed [olfid_pkg::VALUE_W-1:0]   left_val,
	input  logic signed [olfid_pkg::VALUE_W-1:0]   right_val,
	input  logic signed [olfid_pkg::VALUE_W-1:0]   wrap_val,
	input  logic                                   live,
	input  logic                                   right_live,
	input  logic                                   match_in,
	output logic                                   match_out,
	output logic signed [olfid_pkg::VALUE_W-1:0]   value
);
	import olfid_pkg::*;

	logic signed [VALUE_W-1:0] value_q;
	logic signed [VALUE_W-1:0] pull_val;
	logic                      match_q;

	// last live cell wraps around to the front entry
	assign pull_val  = right_live ? right_val : wrap_val;
	// true from the first match onward
	assign match_out = match_in | match_q;
	assign value     = value_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD: begin
			end
			CELL_PUSH: begin
				value_q <= left_val;
			end
			CELL_COMPARE: begin
				match_q <= live && (value_q == ctl.key);
			end
			CELL_PULL_MATCH: begin
				if (match_out) begin
					value_q <= pull_val;
				end
			end
			CELL_PULL: begin
				value_q <= pull_val;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/ordered_list_front_insert_delete_core.sv]
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// cell 0 being the front. Insert (kind 0) pushes every cell one place back and
// loads the value into cell 0, and a full list drops the value with status
// "full". Delete (kind 1) first has every cell compare its entry with the
// value, then the cells from the first match on each pull from their back
// neighbor. Clear (kind 3) sets the count to zero. Readout (kind 2) rotates
// the list toward the front once per beat and emits cell 0, so a list of n
// entries gives n beats and comes back in its original order; an empty
// list gives one "empty" beat. One item is worked on at a time: in_ch.ready
// is low during a delete or a readout and while the output register holds a
// beat that is not being taken. Every beat carries the entry count after
// the operation, modulo 32, and last marks the final beat of an item.
// Entries need no clearing after reset; the count, state and output valid reset.
module ordered_list_front_insert_delete_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	olfid_stream_if.sink    in_ch,
	olfid_stream_if.source  out_ch
);
	import olfid_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MATCH = 3'b010,
		ST_READ  = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   rd_q, rd_d;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic               out_free;
	logic               in_fire;
	logic               full;
	logic               found;
	logic               emit;
	out_item_t          emit_item;
	cell_ctl_t          ctl;

	logic signed [VALUE_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]       live;
	logic [CAPACITY:0]         match_chain;

	// output register frees up when empty or when its beat is taken
	assign out_free     = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE) && out_free;
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign full         = (count_q == CNT_W'(CAPACITY));
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// cell row
	assign match_chain[0] = 1'b0;
	assign found          = match_chain[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_val;
		logic signed [VALUE_W-1:0] right_val;
		logic                      right_live;

		assign live[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_front
			assign left_val = ctl.key;
		end else begin : g_inner
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_back
			assign right_val  = cell_val[0];
			assign right_live = 1'b0;
		end else begin : g_mid
			assign right_val  = cell_val[i+1];
			assign right_live = live[i+1];
		end

		olfid_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_val   (left_val),
			.right_val  (right_val),
			.wrap_val   (cell_val[0]),
			.live       (live[i]),
			.right_live (right_live),
			.match_in   (match_chain[i]),
			.match_out  (match_chain[i+1]),
			.value      (cell_val[i])
		);
	end

	// sequencing and result build
	always_comb begin
		logic [CNT_W+COUNT_W-1:0] cnt_ext;

		state_d   = state_q;
		count_d   = count_q;
		rd_d      = rd_q;
		emit      = 1'b0;
		ctl.op    = CELL_HOLD;
		ctl.key   = in_ch.data.value;
		emit_item.status     = STATUS_EMPTY;
		emit_item.item_value = in_ch.data.value;
		emit_item.last       = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_ch.data.kind)
						KIND_INSERT: begin
							emit = 1'b1;
							if (full) begin
								emit_item.status = STATUS_FULL;
							end else begin
								ctl.op           = CELL_PUSH;
								count_d          = count_q + CNT_W'(1);
								emit_item.status = STATUS_INSERTED;
							end
						end
						KIND_DELETE: begin
							ctl.op  = CELL_COMPARE;
							state_d = ST_MATCH;
						end
						KIND_READ: begin
							if (count_q == '0) begin
								emit             = 1'b1;
								emit_item.status = STATUS_EMPTY;
							end else begin
								rd_d    = '0;
								state_d = ST_READ;
							end
						end
						KIND_CLEAR: begin
							emit             = 1'b1;
							count_d          = '0;
							emit_item.status = STATUS_CLEARED;
						end
						default: begin
						end
					endcase
				end
			end
			ST_MATCH: begin
				emit_item.item_value = out_data_q.item_value;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (found) begin
						ctl.op           = CELL_PULL_MATCH;
						count_d          = count_q - CNT_W'(1);
						emit_item.status = STATUS_REMOVED;
					end else begin
						emit_item.status = STATUS_NOT_FOUND;
					end
				end
			end
			ST_READ: begin
				emit_item.status     = STATUS_ENTRY;
				emit_item.item_value = cell_val[0];
				emit_item.last       = (rd_q + CNT_W'(1) == count_q);
				if (out_free) begin
					emit   = 1'b1;
					ctl.op = CELL_PULL;
					rd_d   = rd_q + CNT_W'(1);
					if (emit_item.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// count reported modulo 32
		cnt_ext               = {{COUNT_W{1'b0}}, count_d};
		emit_item.entry_count = cnt_ext[COUNT_W-1:0];
	end

	// state, count, read index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_q    <= rd_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload; a delete parks its key in the payload field until the result
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_item;
		end else if (in_fire) begin
			out_data_q.item_value <= in_ch.data.value;
		end
	end

endmodule

[rtl/core/olfid_checker.sv]
`timescale 1ns / 1ps

module olfid_checker #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  olfid_pkg::out_item_t  out_data
);
	import olfid_pkg::*;

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// more readout beats pending, so no new item is taken
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_ENTRY && !out_data.last |-> !in_ready)
		else $error("input accepted in the middle of a readout");

	// single-beat results end their item and empty ones report zero entries
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_ENTRY |-> out_data.last)
		else $error("single-beat result without last");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_EMPTY || out_data.status == STATUS_CLEARED)
		|-> out_data.entry_count == '0)
		else $error("empty or cleared list reports entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY >= 32) || (int'(out_data.entry_count) <= CAPACITY))
		else $error("entry count beyond capacity");

endmodule

bind ordered_list_front_insert_delete_core olfid_checker #(
	.CAPACITY (CAPACITY)
) u_olfid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
